### sv/assert_macros.svh
// assertion macros for the span generator unit
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### sv/fesg_pkg.sv
// widths, sequencer state and control bits for the filled ellipse span generator
// no dependencies
package fesg_pkg;

   localparam int COORD_BITS = 10;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int PROD_BITS  = 4 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SQ_BITS-1:0]    sq_type;
   typedef logic [PROD_BITS-1:0]  prod_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_MUL_YY,
      ST_MUL_XX,
      ST_MUL_YYAA,
      ST_MUL_AABB,
      ST_THR,
      ST_SRCH_MUL,
      ST_SRCH_CHK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic load_aa;
      logic load_bb;
      logic load_yy;
      logic load_xx;
      logic load_yyaa;
      logic load_thr;
      logic step_x;
      logic out_write;
   } ctrl_type;

endpackage

### sv/filled_ellipse_span_generator_unit.sv
// filled ellipse span generator: one shared multiplier under a small sequencer
// depends on fesg_pkg and assert_macros.svh
//
// sequence: row 0 skips setup and search and gives the half width as its span;
// other rows run a setup of six products through the single multiplier plus a
// threshold subtract, then a search of one-pixel steps, each one multiply and
// one compare; a result waits in the finish state until the output is free
// throughput: one request at a time, the next is taken once the result is
// registered; a waiting result does not block acceptance
// reset: synchronous, clears the sequencer, the result valid and the stored
// span and shrink
`include "assert_macros.svh"

module filled_ellipse_span_generator_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fesg_pkg::coord_type  req_half_width,
   input  fesg_pkg::coord_type  req_half_height,
   input  fesg_pkg::coord_type  req_row,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fesg_pkg::coord_type  rsp_span_half,
   output fesg_pkg::coord_type  rsp_row_out
);
   import fesg_pkg::*;

   state_type state_ff, state_in;
   ctrl_type  ctl;

   coord_type a_ff, b_ff, y_ff, x_ff, x_in;
   coord_type prev_span_ff, prev_shrink_ff;
   coord_type span_out_ff, row_out_ff;
   logic      rsp_valid_ff;
   logic      zero_row_ff;

   sq_type    aa_ff, bb_ff, yy_ff, xx_ff;
   prod_type  yyaa_ff, prod_ff;
   logic signed [PROD_BITS:0] thr_ff;

   sq_type    mul_a, mul_b;
   logic      accept;
   logic      inside_now;
   logic      out_free;

   logic [COORD_BITS:0] up, shrink_ext, diff;
   coord_type           start_x;
   coord_type           shrink_new;

   assign accept   = req_valid && ctl.req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // search start: one past the previous span minus the previous shrink, clamped at zero and at the largest coordinate
   always_comb begin
      up         = {1'b0, prev_span_ff} + {{COORD_BITS{1'b0}}, 1'b1};
      shrink_ext = {1'b0, prev_shrink_ff};
      diff       = up - shrink_ext;
      if (shrink_ext >= up) begin
         start_x = '0;
      end else if (diff[COORD_BITS]) begin
         start_x = '1;
      end else begin
         start_x = diff[COORD_BITS-1:0];
      end
   end

   // point is inside when x*x*b*b <= a*a*b*b - y*y*a*a
   assign inside_now = $signed({1'b0, prod_ff}) <= thr_ff;

   assign shrink_new = (zero_row_ff || (x_ff > prev_span_ff)) ? '0 : (prev_span_ff - x_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_row == '0) ? ST_FINISH : ST_MUL_AA;
            end
         end
         ST_MUL_AA:   state_in = ST_MUL_BB;
         ST_MUL_BB:   state_in = ST_MUL_YY;
         ST_MUL_YY:   state_in = ST_MUL_XX;
         ST_MUL_XX:   state_in = ST_MUL_YYAA;
         ST_MUL_YYAA: state_in = ST_MUL_AABB;
         ST_MUL_AABB: state_in = ST_THR;
         ST_THR:      state_in = ST_SRCH_CHK;
         ST_SRCH_MUL: state_in = ST_SRCH_CHK;
         ST_SRCH_CHK: begin
            state_in = (x_ff == '0 || inside_now) ? ST_FINISH : ST_SRCH_MUL;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs and multiplier operand select
   always_comb begin
      ctl   = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
         end
         ST_MUL_AA: begin
            mul_a = SQ_BITS'(a_ff);
            mul_b = SQ_BITS'(a_ff);
         end
         ST_MUL_BB: begin
            ctl.load_aa = 1'b1;
            mul_a = SQ_BITS'(b_ff);
            mul_b = SQ_BITS'(b_ff);
         end
         ST_MUL_YY: begin
            ctl.load_bb = 1'b1;
            mul_a = SQ_BITS'(y_ff);
            mul_b = SQ_BITS'(y_ff);
         end
         ST_MUL_XX: begin
            ctl.load_yy = 1'b1;
            mul_a = SQ_BITS'(x_ff);
            mul_b = SQ_BITS'(x_ff);
         end
         ST_MUL_YYAA: begin
            ctl.load_xx = 1'b1;
            mul_a = yy_ff;
            mul_b = aa_ff;
         end
         ST_MUL_AABB: begin
            ctl.load_yyaa = 1'b1;
            mul_a = aa_ff;
            mul_b = bb_ff;
         end
         ST_THR: begin
            ctl.load_thr = 1'b1;
            mul_a = xx_ff;
            mul_b = bb_ff;
         end
         ST_SRCH_MUL: begin
            mul_a = xx_ff;
            mul_b = bb_ff;
         end
         ST_SRCH_CHK: begin
            ctl.step_x = (x_ff != '0) && !inside_now;
         end
         ST_FINISH: begin
            ctl.out_write = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_comb begin
      x_in = x_ff;
      if (accept) begin
         x_in = (req_row == '0) ? req_half_width : start_x;
      end else if (ctl.step_x) begin
         x_in = x_ff - COORD_BITS'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         prev_span_ff   <= '0;
         prev_shrink_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ctl.out_write) begin
            rsp_valid_ff   <= 1'b1;
            prev_span_ff   <= x_ff;
            prev_shrink_ff <= shrink_new;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(mul_a * mul_b);
      x_ff    <= x_in;
      if (accept) begin
         a_ff        <= req_half_width;
         b_ff        <= req_half_height;
         y_ff        <= req_row;
         zero_row_ff <= (req_row == '0);
      end
      if (ctl.load_aa) begin
         aa_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (ctl.load_bb) begin
         bb_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (ctl.load_yy) begin
         yy_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (ctl.load_xx) begin
         xx_ff <= prod_ff[SQ_BITS-1:0];
      end else if (ctl.step_x) begin
         // (x-1)^2 = x^2 - 2x + 1
         xx_ff <= xx_ff - SQ_BITS'({x_ff, 1'b0}) + SQ_BITS'(1);
      end
      if (ctl.load_yyaa) begin
         yyaa_ff <= prod_ff;
      end
      if (ctl.load_thr) begin
         thr_ff <= $signed({1'b0, prod_ff}) - $signed({1'b0, yyaa_ff});
      end
      if (ctl.out_write) begin
         span_out_ff <= x_ff;
         row_out_ff  <= y_ff;
      end
   end

   assign req_ready     = ctl.req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_span_half = span_out_ff;
   assign rsp_row_out   = row_out_ff;

   `ASSERT_AT(a_busy_after_accept, clock, reset, accept |=> !req_ready)
   `ASSERT_AT(a_nonzero_row_runs_setup, clock, reset,
      (accept && req_row != '0) |=> state_ff == ST_MUL_AA)
   `ASSERT_AT(a_square_tracks_x, clock, reset,
      state_ff == ST_SRCH_MUL |-> xx_ff == SQ_BITS'(SQ_BITS'(x_ff) * SQ_BITS'(x_ff)))
   `ASSERT_AT(a_write_updates_state, clock, reset,
      ctl.out_write |=> rsp_valid_ff && span_out_ff == prev_span_ff)
   `ASSERT_NEVER(a_step_from_zero, clock, reset, ctl.step_x && x_ff == '0)

endmodule
